[sv/afw_pkg.sv]
`default_nettype none

package afw_pkg;

  localparam int AFW_MAX_WIDTH  = 512;
  localparam int AFW_MAX_HEIGHT = 512;
  localparam int AFW_FRAC_BITS  = 16;
  localparam int AFW_QDEPTH     = 8;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 9;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int DIM_W      = 10;
  localparam int COEF_W     = 24;
  localparam int OFS_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SCATTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd7;

  localparam logic [DIM_W-1:0]  DIM_RST  = 10'd512;
  localparam logic [COEF_W-1:0] COEF_ONE = 24'd65536;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic               in_frame;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } afw_ctl_t;

endpackage

`default_nettype wire

[sv/afw_fifo.sv]
`default_nettype none

module afw_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [DATA_W-1:0]            wdata,
  input  wire logic                         pop,
  output logic      [DATA_W-1:0]            rdata,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   cnt
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = entry_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CW'(DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_cnt_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

[sv/afw_front.sv]
`default_nettype none

module afw_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16,
  parameter int ADDR_W     = 18
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     cfg_wr_en,
  input  wire logic [afw_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [afw_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  input  wire logic [afw_pkg::FUNC_W-1:0]               in_tuser,
  input  wire logic [afw_pkg::IN_DATA_W-1:0]            in_tdata,
  input  wire logic [$clog2(afw_pkg::AFW_QDEPTH+1)-1:0] q_cnt,
  output logic                                          push,
  output afw_pkg::afw_ctl_t                             push_ctl,
  output logic      [ADDR_W-1:0]                        push_addr,
  output logic      [afw_pkg::PIX_W-1:0]                push_data
);

  import afw_pkg::*;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int PROD_W  = COEF_W + COORD_W + 1;
  localparam int OFS_SHW = OFS_W + FRAC_BITS + 2;
  localparam int SUM_W   = ((PROD_W > OFS_SHW) ? PROD_W : OFS_SHW) + 2;
  localparam int QW      = SUM_W - FRAC_BITS;
  localparam int WD      = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int HD      = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
  localparam int CNT_W   = $clog2(AFW_QDEPTH + 1);

  // configuration
  logic        [DIM_W-1:0]  fw_r, fh_r;
  logic signed [COEF_W-1:0] cxx_r, cxy_r, cyx_r, cyy_r;
  logic signed [OFS_W-1:0]  ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= DIM_RST;
      fh_r  <= DIM_RST;
      cxx_r <= COEF_ONE;
      cxy_r <= '0;
      ox_r  <= '0;
      cyx_r <= '0;
      cyy_r <= COEF_ONE;
      oy_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_r  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_r  <= cfg_wdata[DIM_W-1:0];
        REG_COEF_XX:      cxx_r <= cfg_wdata[COEF_W-1:0];
        REG_COEF_XY:      cxy_r <= cfg_wdata[COEF_W-1:0];
        REG_OFFSET_X:     ox_r  <= cfg_wdata[OFS_W-1:0];
        REG_COEF_YX:      cyx_r <= cfg_wdata[COEF_W-1:0];
        REG_COEF_YY:      cyy_r <= cfg_wdata[COEF_W-1:0];
        REG_OFFSET_Y:     oy_r  <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode and credit check
  logic               accept;
  logic [CNT_W:0]     occ;
  logic [COORD_W-1:0] px, py;
  logic [PIX_W-1:0]   rgb;

  assign px  = in_tdata[8:0];
  assign py  = in_tdata[17:9];
  assign rgb = {in_tdata[25:18], in_tdata[33:26], in_tdata[41:34]};

  logic s1_v_r, s2_v_r, s3_v_r;

  assign occ = {1'b0, q_cnt} + (CNT_W + 1)'(s1_v_r) + (CNT_W + 1)'(s2_v_r)
             + (CNT_W + 1)'(s3_v_r);
  assign in_tready = (occ < (CNT_W + 1)'(AFW_QDEPTH));
  assign accept    = in_tvalid && in_tready;

  // stage 1: products
  logic        [FUNC_W-1:0]  s1_func_r;
  logic        [COORD_W-1:0] s1_px_r, s1_py_r;
  logic        [PIX_W-1:0]   s1_rgb_r;
  logic signed [PROD_W-1:0]  s1_pxx_r, s1_pxy_r, s1_pyx_r, s1_pyy_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_tuser;
      s1_px_r   <= px;
      s1_py_r   <= py;
      s1_rgb_r  <= rgb;
      s1_pxx_r  <= cxx_r * $signed({1'b0, px});
      s1_pxy_r  <= cxy_r * $signed({1'b0, py});
      s1_pyx_r  <= cyx_r * $signed({1'b0, px});
      s1_pyy_r  <= cyy_r * $signed({1'b0, py});
    end
  end

  // stage 2: sums, bounds test, classification
  logic signed [SUM_W-1:0] ax, ay;
  logic        [QW-1:0]    qx, qy;
  logic        [WD-1:0]    w_lim;
  logic        [HD-1:0]    h_lim;
  logic                    hit, in_store;
  afw_ctl_t                s2_ctl;
  logic        [XW-1:0]    s2_x;
  logic        [YW-1:0]    s2_y;
  logic        [PIX_W-1:0] s2_data;

  always_comb begin
    ax = SUM_W'(s1_pxx_r) + SUM_W'(s1_pxy_r) + (SUM_W'(ox_r) <<< FRAC_BITS);
    ay = SUM_W'(s1_pyx_r) + SUM_W'(s1_pyy_r) + (SUM_W'(oy_r) <<< FRAC_BITS);
    qx = ax[SUM_W-1:FRAC_BITS];
    qy = ay[SUM_W-1:FRAC_BITS];
    w_lim = (WD'(fw_r) > WD'(MAX_WIDTH)) ? WD'(MAX_WIDTH) : WD'(fw_r);
    h_lim = (HD'(fh_r) > HD'(MAX_HEIGHT)) ? HD'(MAX_HEIGHT) : HD'(fh_r);
    hit = !ax[SUM_W-1] && !ay[SUM_W-1] && (qx < QW'(w_lim)) && (qy < QW'(h_lim));
    in_store = (WD'(s1_px_r) < WD'(MAX_WIDTH)) && (HD'(s1_py_r) < HD'(MAX_HEIGHT));

    s2_ctl  = '0;
    s2_x    = XW'(s1_px_r);
    s2_y    = YW'(s1_py_r);
    s2_data = '0;
    case (s1_func_r)
      FUNC_CLEAR: begin
        s2_ctl.wr_en = in_store;
      end
      FUNC_SCATTER: begin
        s2_ctl.wr_en    = hit;
        s2_ctl.in_frame = hit;
        s2_ctl.dest_x   = hit ? qx[COORD_W-1:0] : '0;
        s2_ctl.dest_y   = hit ? qy[COORD_W-1:0] : '0;
        s2_x            = XW'(qx);
        s2_y            = YW'(qy);
        s2_data         = s1_rgb_r;
      end
      FUNC_READ: begin
        s2_ctl.rd_en = in_store;
      end
      default: ;
    endcase
  end

  afw_ctl_t            s2_ctl_r, s3_ctl_r;
  logic [XW-1:0]       s2_x_r;
  logic [YW-1:0]       s2_y_r;
  logic [PIX_W-1:0]    s2_data_r, s3_data_r;
  logic [ADDR_W-1:0]   s3_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // stage 3: store address
  always_ff @(posedge clk) begin
    s2_ctl_r  <= s2_ctl;
    s2_x_r    <= s2_x;
    s2_y_r    <= s2_y;
    s2_data_r <= s2_data;
    s3_ctl_r  <= s2_ctl_r;
    s3_data_r <= s2_data_r;
    s3_addr_r <= ADDR_W'(s2_y_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s2_x_r);
  end

  assign push      = s3_v_r;
  assign push_ctl  = s3_ctl_r;
  assign push_addr = s3_addr_r;
  assign push_data = s3_data_r;

endmodule

`default_nettype wire

[sv/afw_back.sv]
`default_nettype none

module afw_back #(
  parameter int ADDR_W = 18,
  parameter int DEPTH  = 262144
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_empty,
  input  wire afw_pkg::afw_ctl_t                 q_ctl,
  input  wire logic [ADDR_W-1:0]                 q_addr,
  input  wire logic [afw_pkg::PIX_W-1:0]         q_data,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic                                   out_tuser,  // in_frame
  output logic      [afw_pkg::OUT_DATA_W-1:0]    out_tdata   // dest_x, dest_y, red, green, blue
);

  import afw_pkg::*;

  logic [PIX_W-1:0] frame_store_r [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic             m_v_r, out_v_r;
  afw_ctl_t         m_ctl_r;
  logic             m_adv, out_free;

  logic [COORD_W-1:0] out_dx_r, out_dy_r;
  logic               out_hit_r;
  logic [PIX_W-1:0]   out_rgb_r;

  assign out_free = !out_v_r || out_tready;
  assign m_adv    = m_v_r && out_free;
  assign pop      = !q_empty && (!m_v_r || m_adv);

  always_ff @(posedge clk) begin
    if (pop && q_ctl.wr_en) begin
      frame_store_r[q_addr] <= q_data;
    end
    if (pop && q_ctl.rd_en) begin
      rd_data_r <= frame_store_r[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        m_v_r <= 1'b1;
      end else if (m_adv) begin
        m_v_r <= 1'b0;
      end
      if (m_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_ctl_r <= q_ctl;
    end
    if (m_adv) begin
      out_dx_r  <= m_ctl_r.dest_x;
      out_dy_r  <= m_ctl_r.dest_y;
      out_hit_r <= m_ctl_r.in_frame;
      out_rgb_r <= m_ctl_r.rd_en ? rd_data_r : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {6'b0, out_rgb_r[7:0], out_rgb_r[15:8], out_rgb_r[23:16],
                       out_dy_r, out_dx_r};

`ifndef SYNTH
  a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !(q_ctl.wr_en && q_ctl.rd_en))
    else $error("read and write on one item");

  a_hit_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_hit_r) |-> (out_rgb_r == '0))
    else $error("scatter result carries read color");
`endif

endmodule

`default_nettype wire

[sv/affine_forward_warp_unit.sv]
// Throughput: one item per cycle while in_tready is high and the output is ready;
// a 3-stage front pipe (multiply, sum/bounds, address) feeds an 8-entry queue
// ahead of the single-port frame store stage.
// Reset: control, queue and configuration registers return to defaults;
// the frame store is not initialized and has no clearing pass.
`default_nettype none

module affine_forward_warp_unit #(
  parameter int MAX_WIDTH  = afw_pkg::AFW_MAX_WIDTH,
  parameter int MAX_HEIGHT = afw_pkg::AFW_MAX_HEIGHT,
  parameter int FRAC_BITS  = afw_pkg::AFW_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [afw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [afw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [afw_pkg::FUNC_W-1:0]        in_tuser,   // func
  input  wire logic [afw_pkg::IN_DATA_W-1:0]     in_tdata,   // pix_x, pix_y, red, green, blue
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic                                   out_tuser,  // in_frame
  output logic      [afw_pkg::OUT_DATA_W-1:0]    out_tdata   // dest_x, dest_y, red, green, blue
);

  import afw_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CTL_W  = $bits(afw_ctl_t);
  localparam int Q_W    = CTL_W + ADDR_W + PIX_W;
  localparam int CNT_W  = $clog2(AFW_QDEPTH + 1);

  logic              push, pop, q_empty;
  afw_ctl_t          push_ctl, q_ctl;
  logic [ADDR_W-1:0] push_addr, q_addr;
  logic [PIX_W-1:0]  push_data, q_data;
  logic [Q_W-1:0]    q_rdata;
  logic [CNT_W-1:0]  q_cnt;

  afw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_cnt     (q_cnt),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_addr (push_addr),
    .push_data (push_data)
  );

  afw_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (AFW_QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_ctl, push_addr, push_data}),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .cnt   (q_cnt)
  );

  assign q_ctl  = q_rdata[Q_W-1 -: CTL_W];
  assign q_addr = q_rdata[PIX_W +: ADDR_W];
  assign q_data = q_rdata[PIX_W-1:0];

  afw_back #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctl      (q_ctl),
    .q_addr     (q_addr),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
